/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRMS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("srms assertion failed");
`define SRMS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("srms assertion failed");
`else
`define SRMS_ASSERT(lbl, clk, rst, prop)
`define SRMS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/srms_pkg.sv */
// shared types, widths and constants of the stereo rms level meter
package srms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int SMOOTH_W   = 17;
   localparam int BLEN_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int PROD_W     = 32;
   localparam int SCALED_W   = 18;
   localparam int SQ_W       = 36;
   localparam int LEVEL_W    = 18;
   localparam int COUNT_W    = 32;

   localparam int MAX_BLOCK_SAMPLES_DEF = 1024;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 17'd52429;
   localparam logic [BLEN_W-1:0]   BLEN_RESET   = 11'd256;
   localparam logic [SMOOTH_W-1:0] SMOOTH_UNITY = 17'd65536;

   localparam logic [PROD_W-1:0] SCALE_ROUND = 32'd4096;
   localparam int SCALE_SHIFT = 13;
   localparam int BLEND_ROUND = 32768;
   localparam int BLEND_SHIFT = 16;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN         = 2'd0,
      CSR_SMOOTHING    = 2'd1,
      CSR_BLOCK_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] block_rms;
      logic [LEVEL_W-1:0] smoothed_level;
      logic [COUNT_W-1:0] blocks_done;
   } rsp_word_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_ROOT,
      BK_ROUND,
      BK_MIX,
      BK_BLEND,
      BK_HOLD
   } bk_state_type;

   typedef struct packed {
      logic load_div;
      logic step_div;
      logic load_root;
      logic step_root;
      logic round_root;
      logic mix;
      logic blend;
      logic load_out;
   } bk_ctrl_type;

endpackage

/* rtl/srms_lane.sv */
// one channel lane: magnitude, gain, rounding to q3.15 and squaring
module srms_lane (
   input  logic                                clock,
   input  logic signed [srms_pkg::SAMPLE_W-1:0] sample,
   input  logic [srms_pkg::GAIN_W-1:0]          gain,
   output logic [srms_pkg::SQ_W-1:0]            square
);
   import srms_pkg::*;

   logic [SAMPLE_W-1:0] mag;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   rounded;
   logic [SCALED_W-1:0] scaled;
   logic [SQ_W-1:0]     sq_ff;
   logic [SQ_W-1:0]     sq_in;

   always_comb begin
      // full scale negative maps to 0x8000, which is right as unsigned
      mag     = sample[SAMPLE_W-1] ? (~$unsigned(sample) + 1'b1) : $unsigned(sample);
      prod_in = PROD_W'(mag) * PROD_W'(gain);
      rounded = prod_ff + SCALE_ROUND;
      scaled  = rounded[SCALE_SHIFT +: SCALED_W];
      sq_in   = SQ_W'(scaled) * SQ_W'(scaled);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
   end

   assign square = sq_ff;

endmodule

/* rtl/srms_accum.sv */
// merge stage: pair counting, block end detection and sum of squares
`include "assert_macros.svh"
module srms_accum #(
   parameter  int MAX_BLOCK_SAMPLES = srms_pkg::MAX_BLOCK_SAMPLES_DEF,
   localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
   localparam int SUM_W = srms_pkg::SQ_W + $clog2(2 * MAX_BLOCK_SAMPLES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_fire,
   input  logic [srms_pkg::BLEN_W-1:0]     block_length,
   input  logic [srms_pkg::SQ_W-1:0]       sq_left,
   input  logic [srms_pkg::SQ_W-1:0]       sq_right,
   input  logic                            back_done,
   output logic                            busy,
   output logic                            start,
   output logic [SUM_W-1:0]                block_sum,
   output logic [CNT_W-1:0]                block_pairs
);
   import srms_pkg::*;

   logic [CNT_W-1:0] len_eff;
   logic [CNT_W-1:0] cnt_next;
   logic             finish;
   logic [SUM_W-1:0] total;

   logic [CNT_W-1:0] pair_cnt_ff, pair_cnt_in;
   logic             busy_ff, busy_in;
   logic             v1_ff, v2_ff;
   logic             last1_ff, last1_in, last2_ff;
   logic             start_ff, start_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] n_ff;

   always_comb begin
      if (block_length == '0) begin
         len_eff = CNT_W'(1);
      end else if (int'(block_length) > MAX_BLOCK_SAMPLES) begin
         len_eff = CNT_W'(MAX_BLOCK_SAMPLES);
      end else begin
         len_eff = CNT_W'(block_length);
      end
      cnt_next = pair_cnt_ff + 1'b1;
      // a shortened length that is already reached ends the block on this pair
      finish   = (cnt_next >= len_eff);
      total    = acc_ff + SUM_W'(sq_left) + SUM_W'(sq_right);

      pair_cnt_in = pair_cnt_ff;
      if (req_fire) begin
         pair_cnt_in = finish ? '0 : cnt_next;
      end
      last1_in = req_fire && finish;

      busy_in = busy_ff;
      if (back_done) begin
         busy_in = 1'b0;
      end else if (last1_in) begin
         busy_in = 1'b1;
      end

      acc_in = acc_ff;
      if (v2_ff) begin
         acc_in = last2_ff ? '0 : total;
      end
      start_in = v2_ff && last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_cnt_ff <= '0;
         busy_ff     <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         last1_ff    <= 1'b0;
         last2_ff    <= 1'b0;
         start_ff    <= 1'b0;
         acc_ff      <= '0;
      end else begin
         pair_cnt_ff <= pair_cnt_in;
         busy_ff     <= busy_in;
         v1_ff       <= req_fire;
         v2_ff       <= v1_ff;
         last1_ff    <= last1_in;
         last2_ff    <= last1_ff;
         start_ff    <= start_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last1_in) begin
         n_ff <= cnt_next;
      end
      if (start_in) begin
         sum_ff <= total;
      end
   end

   assign busy        = busy_ff;
   assign start       = start_ff;
   assign block_sum   = sum_ff;
   assign block_pairs = n_ff;

   `SRMS_ASSERT(a_start_while_busy, clock, reset, start_ff |-> busy_ff)
   `SRMS_ASSERT(a_acc_cleared_at_start, clock, reset, start_ff |-> (acc_ff == '0))
   `SRMS_ASSERT(a_last_pair_sets_busy, clock, reset, (req_fire && finish) |=> busy_ff)

endmodule

/* rtl/srms_back.sv */
// back stage: mean by long division, rounded square root, smoothing and result register
`include "assert_macros.svh"
module srms_back #(
   parameter  int MAX_BLOCK_SAMPLES = srms_pkg::MAX_BLOCK_SAMPLES_DEF,
   localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
   localparam int SUM_W = srms_pkg::SQ_W + $clog2(2 * MAX_BLOCK_SAMPLES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SUM_W-1:0]              block_sum,
   input  logic [CNT_W-1:0]              block_pairs,
   input  logic [srms_pkg::SMOOTH_W-1:0] smoothing,
   output logic                          done,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output srms_pkg::rsp_word_type        rsp_word
);
   import srms_pkg::*;

   localparam int NUM_W   = SUM_W + 1;
   localparam int DEN_W   = CNT_W + 1;
   localparam int DCNT_W  = $clog2(NUM_W);
   localparam int MIX_W   = SMOOTH_W + LEVEL_W;
   localparam int BLVL_W  = MIX_W - BLEND_SHIFT + 1;

   bk_state_type state_ff, state_in;
   bk_ctrl_type  ctrl;
   logic         out_free;

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]   quot_ff, quot_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DEN_W:0]    shifted;
   logic              div_ge;

   logic [SQ_W-1:0]   rrem_ff, rrem_in;
   logic [SQ_W-1:0]   rres_ff, rres_in;
   logic [SQ_W-1:0]   rbit_ff, rbit_in;
   logic [SQ_W:0]     trial;
   logic              take;

   logic [LEVEL_W:0]   rnd_sum;
   logic [LEVEL_W-1:0] rms_ff, rms_in;
   logic [SMOOTH_W-1:0] alpha;
   logic [MIX_W-1:0]   pa_ff, pa_in;
   logic [MIX_W-1:0]   pb_ff, pb_in;
   logic [MIX_W:0]     blend_sum;
   logic [BLVL_W-1:0]  blend_lvl;
   logic [LEVEL_W-1:0] lvl_new_ff, lvl_new_in;
   logic [LEVEL_W-1:0] level_ff;
   logic [COUNT_W-1:0] count_ff, count_next;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (start) state_in = BK_DIV;
         BK_DIV:   if (dcnt_ff == '0) state_in = BK_ROOT;
         BK_ROOT:  if (rbit_ff[0]) state_in = BK_ROUND;
         BK_ROUND: state_in = BK_MIX;
         BK_MIX:   state_in = BK_BLEND;
         BK_BLEND: state_in = BK_HOLD;
         BK_HOLD:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // control decode
   always_comb begin
      ctrl = '0;
      case (state_ff)
         BK_IDLE:  ctrl.load_div = start;
         BK_DIV: begin
            ctrl.step_div  = 1'b1;
            ctrl.load_root = (dcnt_ff == '0);
         end
         BK_ROOT:  ctrl.step_root  = 1'b1;
         BK_ROUND: ctrl.round_root = 1'b1;
         BK_MIX:   ctrl.mix        = 1'b1;
         BK_BLEND: ctrl.blend      = 1'b1;
         BK_HOLD:  ctrl.load_out   = out_free;
         default:  ctrl = '0;
      endcase
   end

   // restoring division, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      div_ge  = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dcnt_in = dcnt_ff;
      if (ctrl.load_div) begin
         // (sum + n) / (2n) rounds the mean to nearest
         num_in  = NUM_W'(block_sum) + NUM_W'(block_pairs);
         den_in  = {block_pairs, 1'b0};
         rem_in  = '0;
         quot_in = '0;
         dcnt_in = DCNT_W'(NUM_W - 1);
      end else if (ctrl.step_div) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = div_ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         // the mean never exceeds one square, so upper quotient bits are zero
         quot_in = {quot_ff[SQ_W-2:0], div_ge};
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   // digit by digit square root, one result bit a cycle
   always_comb begin
      trial   = (SQ_W+1)'(rres_ff) + (SQ_W+1)'(rbit_ff);
      take    = ({1'b0, rrem_ff} >= trial);
      rrem_in = rrem_ff;
      rres_in = rres_ff;
      rbit_in = rbit_ff;
      if (ctrl.load_root) begin
         rrem_in = quot_in;
         rres_in = '0;
         rbit_in = SQ_W'(1) << (SQ_W - 2);
      end else if (ctrl.step_root) begin
         rrem_in = take ? SQ_W'({1'b0, rrem_ff} - trial) : rrem_ff;
         rres_in = take ? ((rres_ff >> 1) + rbit_ff) : (rres_ff >> 1);
         rbit_in = rbit_ff >> 2;
      end
   end

   always_comb begin
      rnd_sum = (LEVEL_W+1)'(rres_ff) + {{LEVEL_W{1'b0}}, (rrem_ff > rres_ff)};
      rms_in  = rnd_sum[LEVEL_W] ? LEVEL_MAX : rnd_sum[LEVEL_W-1:0];
      // weights above one hold the level
      alpha   = (smoothing > SMOOTH_UNITY) ? SMOOTH_UNITY : smoothing;
      pa_in   = MIX_W'(alpha) * MIX_W'(level_ff);
      pb_in   = MIX_W'(SMOOTH_UNITY - alpha) * MIX_W'(rms_ff);
      blend_sum = (MIX_W+1)'(pa_ff) + (MIX_W+1)'(pb_ff) + (MIX_W+1)'(BLEND_ROUND);
      blend_lvl = blend_sum[MIX_W:BLEND_SHIFT];
      lvl_new_in = (|blend_lvl[BLVL_W-1:LEVEL_W]) ? LEVEL_MAX : blend_lvl[LEVEL_W-1:0];
      count_next = count_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.load_out) begin
            level_ff <= lvl_new_ff;
            count_ff <= count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dcnt_ff <= dcnt_in;
      rrem_ff <= rrem_in;
      rres_ff <= rres_in;
      rbit_ff <= rbit_in;
      if (ctrl.round_root) begin
         rms_ff <= rms_in;
      end
      if (ctrl.mix) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ctrl.blend) begin
         lvl_new_ff <= lvl_new_in;
      end
      if (ctrl.load_out) begin
         rsp_word_ff.block_rms      <= rms_ff;
         rsp_word_ff.smoothed_level <= lvl_new_ff;
         rsp_word_ff.blocks_done    <= count_next;
      end
   end

   assign done      = ctrl.load_out;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SRMS_ASSERT(a_start_when_idle, clock, reset, start |-> (state_ff == BK_IDLE))
   `SRMS_ASSERT(a_rem_below_divisor, clock, reset, (state_ff == BK_DIV) |-> (rem_ff < den_ff))
   `SRMS_ASSERT(a_load_gives_word, clock, reset, ctrl.load_out |=> rsp_valid_ff)
   `SRMS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && state_ff == BK_IDLE))

endmodule

/* rtl/stereo_rms_level_meter_core.sv */
// stereo rms level meter: channels, configuration registers and the lanes, merge and back stage
//
// req channel: one word per stereo pair of signed q1.15 samples, taken when
// req_valid is high and req_stall low. rsp channel: one word per finished block
// with the block rms, the smoothed level (both unsigned q3.15) and the block count.
// csr port: csr_wr_en writes csr_wdata into the register csr_index selects
// (gain, smoothing, block length); other indexes are ignored.
// within a block one pair is taken every cycle: two lanes scale and square the
// left and right samples in parallel and a merge stage sums them.
// the last pair of a block raises req_stall while the back stage works out the
// mean by long division (one bit a cycle) and the rounded square root; the word
// reaches rsp_valid after the lanes, the merge stage and the back stage states
// div, root, round, mix, blend and hold.
// while rsp_stall holds a word, req keeps flowing until the next block ends,
// which then waits in the back stage with req_stall high.
// reset (synchronous) clears the counts, the sum, the level and the pending word,
// and loads the registers with gain 0.5, smoothing 0.8 and 256 pairs a block.
module stereo_rms_level_meter_core #(
   parameter int MAX_BLOCK_SAMPLES = srms_pkg::MAX_BLOCK_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  srms_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output srms_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_wr_en,
   input  logic [srms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srms_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srms_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int SUM_W = SQ_W + $clog2(2 * MAX_BLOCK_SAMPLES);

   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [BLEN_W-1:0]   blen_ff, blen_in;

   logic             req_fire;
   logic             busy;
   logic [SQ_W-1:0]  sq_left;
   logic [SQ_W-1:0]  sq_right;
   logic             start;
   logic [SUM_W-1:0] block_sum;
   logic [CNT_W-1:0] block_pairs;
   logic             back_done;

   always_comb begin
      gain_in   = gain_ff;
      smooth_in = smooth_ff;
      blen_in   = blen_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN:         gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_SMOOTHING:    smooth_in = csr_wdata[SMOOTH_W-1:0];
            CSR_BLOCK_LENGTH: blen_in   = csr_wdata[BLEN_W-1:0];
            default:          gain_in   = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         smooth_ff <= SMOOTH_RESET;
         blen_ff   <= BLEN_RESET;
      end else begin
         gain_ff   <= gain_in;
         smooth_ff <= smooth_in;
         blen_ff   <= blen_in;
      end
   end

   assign req_fire  = req_valid && !busy;
   assign req_stall = busy;

   srms_lane u_lane_left (
      .clock  (clock),
      .sample (req_word.left_sample),
      .gain   (gain_ff),
      .square (sq_left)
   );

   srms_lane u_lane_right (
      .clock  (clock),
      .sample (req_word.right_sample),
      .gain   (gain_ff),
      .square (sq_right)
   );

   srms_accum #(
      .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .block_length (blen_ff),
      .sq_left      (sq_left),
      .sq_right     (sq_right),
      .back_done    (back_done),
      .busy         (busy),
      .start        (start),
      .block_sum    (block_sum),
      .block_pairs  (block_pairs)
   );

   srms_back #(
      .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .block_sum   (block_sum),
      .block_pairs (block_pairs),
      .smoothing   (smooth_ff),
      .done        (back_done),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule
